@@ hw/rtl/igo_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// igo_pkg
// Shared widths and the command and status bundles between the controller
// and the datapath of the interleave grid overlay.
// ----------------------------------------------------------------------------
package igo_pkg;

    localparam int PIX_W      = 32;
    localparam int SIZE_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef struct packed {
        logic latch_frame;   // frame-start beat accepted: capture its fields
        logic pixel_live;    // ordinary beat accepted: process the input pixel
        logic pixel_emit;    // process the captured frame-start pixel
        logic ease_mul;      // first half of an ease: products
        logic ease_add;      // second half of an ease: sum, shift, clamp
        logic ease_sel_h;    // 0 width, 1 height
        logic beat_load;     // jump both sizes to the beat values
        logic band_load;     // take band sizes and line width for the frame
        logic div_start;
        logic div_step;
        logic div_sel_h;     // 0 width by band width, 1 height by band height
        logic store_fso;
        logic store_rpc;
    } igo_cmd_t;

    typedef struct packed {
        logic held;
        logic beat_jump;
        logic div_done;
    } igo_status_t;

endpackage
`default_nettype wire

@@ hw/rtl/igo_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// igo_datapath
// Configuration registers, band easing, remainder divider, row and column
// fill counters, blend and output register.
// ----------------------------------------------------------------------------
module igo_datapath #(
    parameter int MAX_LINE_WIDTH = 4096,
    parameter int MAX_LINES      = 4096,
    parameter int MAX_BAND       = 64
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire igo_pkg::igo_cmd_t           cmd,
    output igo_pkg::igo_status_t             status,
    input  wire                              cfg_we,
    input  wire [igo_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [igo_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire [igo_pkg::PIX_W-1:0]         pixel_in,
    input  wire                              beat,
    input  wire                              hold_frame,
    input  wire [igo_pkg::SIZE_W-1:0]        frame_width,
    input  wire [igo_pkg::SIZE_W-1:0]        frame_height,
    output logic [igo_pkg::PIX_W-1:0]        pixel_out,
    output logic                             frame_start_out
);

    localparam int BW   = $clog2(MAX_BAND + 1);
    localparam int EW   = BW + 16;
    localparam int CW   = $clog2(MAX_LINE_WIDTH);
    localparam int LWW  = $clog2(MAX_LINE_WIDTH + 1);
    localparam int LHW  = $clog2(MAX_LINES + 1);
    localparam int CMPW = (LWW > igo_pkg::SIZE_W) ? LWW : igo_pkg::SIZE_W;
    localparam int CMPH = (LHW > igo_pkg::SIZE_W) ? LHW : igo_pkg::SIZE_W;
    localparam int DVW  = (LWW > LHW) ? LWW : LHW;
    localparam int DCW  = $clog2(DVW + 1);
    localparam int PW   = EW + 10;
    localparam int ACW  = ((PW > 30) ? PW : 30) + 2;
    localparam logic [EW-1:0] EMAX = EW'(MAX_BAND * 65536);
    localparam logic [EW-1:0] EONE = EW'(65536);

    localparam logic [igo_pkg::CFG_IDX_W-1:0] REG_BAND_WIDTH_TARGET  = 3'd0;
    localparam logic [igo_pkg::CFG_IDX_W-1:0] REG_BAND_HEIGHT_TARGET = 3'd1;
    localparam logic [igo_pkg::CFG_IDX_W-1:0] REG_BEAT_BAND_WIDTH    = 3'd2;
    localparam logic [igo_pkg::CFG_IDX_W-1:0] REG_BEAT_BAND_HEIGHT   = 3'd3;
    localparam logic [igo_pkg::CFG_IDX_W-1:0] REG_BEAT_ENABLE        = 3'd4;
    localparam logic [igo_pkg::CFG_IDX_W-1:0] REG_EASE_DURATION      = 3'd5;
    localparam logic [igo_pkg::CFG_IDX_W-1:0] REG_FILL_COLOR         = 3'd6;
    localparam logic [igo_pkg::CFG_IDX_W-1:0] REG_BLEND_MODE         = 3'd7;

    localparam logic [1:0] BLEND_ADD  = 2'd1;
    localparam logic [1:0] BLEND_MEAN = 2'd2;

    // configuration
    logic [6:0]                bwt_reg, bht_reg, bbw_reg, bbh_reg, dur_reg;
    logic                      beat_en_reg;
    logic [igo_pkg::PIX_W-1:0] fill_reg;
    logic [1:0]                mode_reg;

    // frame capture
    logic [igo_pkg::PIX_W-1:0] pix_cap_reg;
    logic                      beat_cap_reg;
    logic [LWW-1:0]            w_cap_reg;
    logic [LHW-1:0]            h_cap_reg;

    // easing
    logic [EW-1:0]             ew_reg, eh_reg;
    logic [PW-1:0]             prod_reg;
    logic signed [16:0]        tt_reg;

    // divider
    logic [BW-1:0]             div_rem_reg, div_dvs_reg;
    logic [DVW-1:0]            div_dvd_reg;
    logic [DCW-1:0]            div_cnt_reg;

    // banding state
    logic [BW-1:0]             bw_reg, bh_reg, rpc_reg, sl_reg, fso_reg;
    logic                      rows_reg, cf_reg, held_reg;
    logic [CW-1:0]             cp_reg;
    logic [LWW-1:0]            lw_reg;

    logic [igo_pkg::PIX_W-1:0] pixel_out_reg;
    logic                      fs_out_reg;

    function automatic logic [igo_pkg::PIX_W-1:0] blend(
        input logic [igo_pkg::PIX_W-1:0] p,
        input logic [igo_pkg::PIX_W-1:0] c,
        input logic [1:0]                mode
    );
        logic [igo_pkg::PIX_W-1:0] r;
        logic [8:0]                t;
        r = '0;
        case (mode)
            BLEND_ADD:
            begin
                for (int s = 0; s < 3; s++)
                begin
                    t = {1'b0, p[8*s +: 8]} + {1'b0, c[8*s +: 8]};
                    r[8*s +: 8] = t[8] ? 8'hFF : t[7:0];
                end
            end
            BLEND_MEAN:
                r = ((p >> 1) & 32'h7F7F7F7F) + ((c >> 1) & 32'h7F7F7F7F);
            default:
                r = c;
        endcase
        return r;
    endfunction

    // ---------------- input clamps ----------------
    logic [LWW-1:0] w_clamp;
    logic [LHW-1:0] h_clamp;

    always_comb
    begin
        if (frame_width == '0)
            w_clamp = LWW'(1);
        else if (CMPW'(frame_width) > CMPW'(MAX_LINE_WIDTH))
            w_clamp = LWW'(MAX_LINE_WIDTH);
        else
            w_clamp = LWW'(frame_width);
        if (frame_height == '0)
            h_clamp = LHW'(1);
        else if (CMPH'(frame_height) > CMPH'(MAX_LINES))
            h_clamp = LHW'(MAX_LINES);
        else
            h_clamp = LHW'(frame_height);
    end

    // ---------------- easing ----------------
    logic [EW-1:0]          ease_cur;
    logic [6:0]             ease_tgt;
    logic [9:0]             keep_k;
    logic signed [8:0]      dd;
    logic [PW-1:0]          prod_next;
    logic signed [16:0]     tt_next;
    logic signed [ACW-1:0]  acc;
    logic [EW-1:0]          eased_next;
    logic [BW-1:0]          bbw_c, bbh_c;

    assign ease_cur  = cmd.ease_sel_h ? eh_reg : ew_reg;
    assign ease_tgt  = cmd.ease_sel_h ? bht_reg : bwt_reg;
    assign keep_k    = 10'(dur_reg) + 10'd448;
    assign dd        = 9'sd64 - $signed({2'b00, dur_reg});
    assign prod_next = PW'(ease_cur) * PW'(keep_k);
    assign tt_next   = $signed({1'b0, ease_tgt}) * dd;
    assign acc       = $signed(ACW'(prod_reg)) + ($signed(ACW'(tt_reg)) <<< 16);

    always_comb
    begin
        if (acc[ACW-1])
            eased_next = '0;
        else if (acc[ACW-1:9] > (ACW-9)'(MAX_BAND * 65536))
            eased_next = EMAX;
        else
            eased_next = acc[9 +: EW];
    end

    assign bbw_c = (32'(bbw_reg) > MAX_BAND) ? BW'(MAX_BAND) : BW'(bbw_reg);
    assign bbh_c = (32'(bbh_reg) > MAX_BAND) ? BW'(MAX_BAND) : BW'(bbh_reg);

    // ---------------- remainder divider ----------------
    logic [BW:0] rem_sh;
    logic [BW:0] rem_sub;

    assign rem_sh  = {div_rem_reg, div_dvd_reg[DVW-1]};
    assign rem_sub = rem_sh - {1'b0, div_dvs_reg};

    // ---------------- per-pixel banding ----------------
    logic                      pix_go;
    logic [igo_pkg::PIX_W-1:0] pix_src;
    logic [BW:0]               rpc_inc;
    logic [BW-1:0]             rpc_next, sl_line, sl_dec, sl_next;
    logic                      rows_line, cf_line, cf_next, fill;
    logic [LWW-1:0]            cp_inc;
    logic [CW-1:0]             cp_next;

    assign pix_go  = cmd.pixel_live | cmd.pixel_emit;
    assign pix_src = cmd.pixel_emit ? pix_cap_reg : pixel_in;
    assign rpc_inc = (BW+1)'(rpc_reg) + (BW+1)'(1);

    always_comb
    begin
        rpc_next  = rpc_reg;
        rows_line = rows_reg;
        cf_line   = cf_reg;
        sl_line   = sl_reg;
        if (cp_reg == '0)
        begin
            if (bh_reg != '0)
            begin
                if (rpc_inc >= {1'b0, bh_reg})
                begin
                    rows_line = ~rows_reg;
                    rpc_next  = '0;
                end
                else
                begin
                    rpc_next = rpc_inc[BW-1:0];
                end
            end
            cf_line = 1'b1;
            sl_line = bw_reg - fso_reg;
        end
        fill    = rows_line | ((bw_reg != '0) & cf_line);
        sl_dec  = (sl_line != '0) ? sl_line - BW'(1) : sl_line;
        cf_next = cf_line;
        sl_next = sl_line;
        if (bw_reg != '0)
        begin
            if (sl_dec == '0)
            begin
                cf_next = ~cf_line;
                sl_next = bw_reg;
            end
            else
            begin
                sl_next = sl_dec;
            end
        end
        cp_inc  = LWW'(cp_reg) + LWW'(1);
        cp_next = (cp_inc >= lw_reg) ? '0 : cp_inc[CW-1:0];
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bwt_reg     <= 7'd1;
            bht_reg     <= 7'd1;
            bbw_reg     <= 7'd1;
            bbh_reg     <= 7'd1;
            beat_en_reg <= 1'b0;
            dur_reg     <= 7'd4;
            fill_reg    <= '0;
            mode_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BAND_WIDTH_TARGET:  bwt_reg     <= cfg_data[6:0];
                REG_BAND_HEIGHT_TARGET: bht_reg     <= cfg_data[6:0];
                REG_BEAT_BAND_WIDTH:    bbw_reg     <= cfg_data[6:0];
                REG_BEAT_BAND_HEIGHT:   bbh_reg     <= cfg_data[6:0];
                REG_BEAT_ENABLE:        beat_en_reg <= cfg_data[0];
                REG_EASE_DURATION:      dur_reg     <= cfg_data[6:0];
                REG_FILL_COLOR:         fill_reg    <= cfg_data;
                REG_BLEND_MODE:         mode_reg    <= cfg_data[1:0];
                default:                ;
            endcase
        end
    end

    // payload captures and arithmetic pipes
    always_ff @(posedge clk)
    begin
        if (cmd.latch_frame)
        begin
            pix_cap_reg  <= pixel_in;
            beat_cap_reg <= beat;
            w_cap_reg    <= w_clamp;
            h_cap_reg    <= h_clamp;
        end
        if (cmd.ease_mul)
        begin
            prod_reg <= prod_next;
            tt_reg   <= tt_next;
        end
        if (cmd.div_start)
        begin
            div_rem_reg <= '0;
            div_dvd_reg <= cmd.div_sel_h ? DVW'(h_cap_reg) : DVW'(w_cap_reg);
            div_dvs_reg <= cmd.div_sel_h ? eh_reg[16 +: BW] : ew_reg[16 +: BW];
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= rem_sh >= {1'b0, div_dvs_reg} ? rem_sub[BW-1:0]
                                                         : rem_sh[BW-1:0];
            div_dvd_reg <= div_dvd_reg << 1;
        end
        if (pix_go)
        begin
            pixel_out_reg <= (!held_reg && fill) ? blend(pix_src, fill_reg, mode_reg)
                                                 : pix_src;
            fs_out_reg    <= cmd.pixel_emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
            ew_reg      <= EONE;
            eh_reg      <= EONE;
            bw_reg      <= '0;
            bh_reg      <= '0;
            rpc_reg     <= '0;
            rows_reg    <= 1'b0;
            sl_reg      <= '0;
            cf_reg      <= 1'b1;
            cp_reg      <= '0;
            fso_reg     <= '0;
            held_reg    <= 1'b0;
            lw_reg      <= LWW'(MAX_LINE_WIDTH);
        end
        else
        begin
            if (cmd.div_start)
                div_cnt_reg <= DCW'(DVW);
            else if (cmd.div_step)
                div_cnt_reg <= div_cnt_reg - DCW'(1);

            if (cmd.latch_frame)
            begin
                held_reg <= hold_frame;
                cp_reg   <= '0;
            end

            if (cmd.ease_add)
            begin
                if (cmd.ease_sel_h)
                    eh_reg <= eased_next;
                else
                    ew_reg <= eased_next;
            end
            else if (cmd.beat_load)
            begin
                ew_reg <= {bbw_c, 16'h0000};
                eh_reg <= {bbh_c, 16'h0000};
            end

            if (cmd.band_load)
            begin
                bw_reg <= ew_reg[16 +: BW];
                bh_reg <= eh_reg[16 +: BW];
                lw_reg <= w_cap_reg;
            end

            if (cmd.store_fso)
                fso_reg <= (bw_reg != '0) ? (div_rem_reg >> 1) : '0;

            if (cmd.store_rpc)
            begin
                rpc_reg  <= (bh_reg != '0) ? (div_rem_reg >> 1) : '0;
                rows_reg <= (bh_reg != '0);
            end

            if (pix_go)
            begin
                rpc_reg  <= rpc_next;
                rows_reg <= rows_line;
                cf_reg   <= cf_next;
                sl_reg   <= sl_next;
                cp_reg   <= cp_next;
            end
        end
    end

    assign status.held      = held_reg;
    assign status.beat_jump = beat_cap_reg & beat_en_reg;
    assign status.div_done  = (div_cnt_reg == '0);

    assign pixel_out       = pixel_out_reg;
    assign frame_start_out = fs_out_reg;

endmodule
`default_nettype wire

@@ hw/rtl/igo_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// igo_ctrl
// Sequencer for frame setup (easing, remainders) and the input and output
// handshakes.
// ----------------------------------------------------------------------------
module igo_ctrl (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire                          frame_start,
    output logic                         out_valid,
    input  wire                          out_stall,
    output igo_pkg::igo_cmd_t            cmd,
    input  wire igo_pkg::igo_status_t    status
);

    localparam logic [3:0] ST_IDLE        = 4'd0;
    localparam logic [3:0] ST_SETUP       = 4'd1;
    localparam logic [3:0] ST_ADD_W       = 4'd2;
    localparam logic [3:0] ST_MUL_H       = 4'd3;
    localparam logic [3:0] ST_ADD_H       = 4'd4;
    localparam logic [3:0] ST_DIV_W_START = 4'd5;
    localparam logic [3:0] ST_DIV_W       = 4'd6;
    localparam logic [3:0] ST_DIV_H_START = 4'd7;
    localparam logic [3:0] ST_DIV_H       = 4'd8;
    localparam logic [3:0] ST_EMIT        = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_busy;
    logic       in_acc;

    assign out_busy = out_valid_reg & out_stall;
    assign in_stall = (state_reg != ST_IDLE) | out_busy;
    assign in_acc   = in_valid & ~in_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (frame_start)
                    begin
                        cmd.latch_frame = 1'b1;
                        state_next      = ST_SETUP;
                    end
                    else
                    begin
                        cmd.pixel_live = 1'b1;
                    end
                end
            end
            ST_SETUP:
            begin
                if (status.held)
                    state_next = ST_EMIT;
                else if (status.beat_jump)
                begin
                    cmd.beat_load = 1'b1;
                    state_next    = ST_DIV_W_START;
                end
                else
                begin
                    cmd.ease_mul = 1'b1;
                    state_next   = ST_ADD_W;
                end
            end
            ST_ADD_W:
            begin
                cmd.ease_add = 1'b1;
                state_next   = ST_MUL_H;
            end
            ST_MUL_H:
            begin
                cmd.ease_mul   = 1'b1;
                cmd.ease_sel_h = 1'b1;
                state_next     = ST_ADD_H;
            end
            ST_ADD_H:
            begin
                cmd.ease_add   = 1'b1;
                cmd.ease_sel_h = 1'b1;
                state_next     = ST_DIV_W_START;
            end
            ST_DIV_W_START:
            begin
                cmd.band_load = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_W;
            end
            ST_DIV_W:
            begin
                if (status.div_done)
                begin
                    cmd.store_fso = 1'b1;
                    state_next    = ST_DIV_H_START;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_DIV_H_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel_h = 1'b1;
                state_next    = ST_DIV_H;
            end
            ST_DIV_H:
            begin
                cmd.div_sel_h = 1'b1;
                if (status.div_done)
                begin
                    cmd.store_rpc = 1'b1;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_EMIT:
            begin
                // hold the frame-start pixel until the output register frees up
                if (!out_busy)
                begin
                    cmd.pixel_emit = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.pixel_live | cmd.pixel_emit)
            out_valid_next = 1'b1;
        else if (out_valid_reg & ~out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.pixel_live && cmd.pixel_emit))
        else $error("live and captured pixel loaded together");

    a_frame_enters_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && frame_start) |=> (state_reg == ST_SETUP))
        else $error("frame-start beat did not start setup");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pixel_emit |-> !(out_valid_reg && out_stall))
        else $error("result overwritten while stalled");

    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result dropped");

endmodule
`default_nettype wire

@@ hw/rtl/interleave_grid_overlay.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// interleave_grid_overlay
// Blends a fill colour into alternating row bands and column segments of a
// raster pixel stream, with per-frame easing of the band sizes.
// ----------------------------------------------------------------------------
// An ordinary pixel is loaded into the output register in the cycle after
//   its beat; one pixel per cycle is sustained within a line while the output
//   is not stalled. A frame-start pixel runs setup first: held, it goes to emit;
//   else a beat jump loads the beat sizes or both sizes are eased, then the
//   bit-serial remainder unit divides width and height (DVW-bit, 13 at defaults).
// Reset: asynchronous, active low; config and band state return to defaults.
// ----------------------------------------------------------------------------
module interleave_grid_overlay #(
    parameter int MAX_LINE_WIDTH = 4096,
    parameter int MAX_LINES      = 4096,
    parameter int MAX_BAND       = 64
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire [igo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [igo_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire                            in_valid,
    output logic                           in_stall,
    input  wire [igo_pkg::PIX_W-1:0]       pixel_in,
    input  wire                            frame_start,
    input  wire                            beat,
    input  wire                            hold_frame,
    input  wire [igo_pkg::SIZE_W-1:0]      frame_width,
    input  wire [igo_pkg::SIZE_W-1:0]      frame_height,
    output logic                           out_valid,
    input  wire                            out_stall,
    output logic [igo_pkg::PIX_W-1:0]      pixel_out,
    output logic                           frame_start_out
);

    igo_pkg::igo_cmd_t    cmd;
    igo_pkg::igo_status_t status;

    assign cfg_ready = 1'b1;

    igo_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .status      (status)
    );

    igo_datapath #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
        .MAX_LINES      (MAX_LINES),
        .MAX_BAND       (MAX_BAND)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_valid & cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .pixel_in        (pixel_in),
        .beat            (beat),
        .hold_frame      (hold_frame),
        .frame_width     (frame_width),
        .frame_height    (frame_height),
        .pixel_out       (pixel_out),
        .frame_start_out (frame_start_out)
    );

endmodule
`default_nettype wire
